// File: hw/rtl/rmf_pkg.sv
// shared constants for the rusanov momentum flux unit
package rmf_pkg;

    // gravity g = 9.81 and g/2 = 4.905 as ratios
    localparam int unsigned G_NUM      = 981;
    localparam int unsigned G_DEN      = 100;
    localparam int unsigned G2_NUM     = 4905;
    localparam int unsigned G2_DEN     = 1000;
    // integer bits that hold the gravity constant
    localparam int unsigned G_INT_BITS = 4;
    // square root digits resolved per pipeline stage
    localparam int unsigned SQ_STEPS   = 2;

endpackage

// File: hw/rtl/rusanov_momentum_flux_unit.sv
// Rusanov (local Lax-Friedrichs) momentum flux at one shallow-water cell interface
//
// One interface request enters on the slave stream: tdata holds vel_left,
// vel_right, depth_left, depth_right (signed fixed point, DATA_WIDTH bits,
// FRAC_BITS fraction bits), lowest field first. One result leaves on the
// master stream: tdata holds momentum_flux, tuser holds the saturated flag.
// NSQ = ceil((DATA_WIDTH + FRAC_BITS + 3) / 4) is the number of wave-speed
// square root stages, two root digits per stage; at the default Q15.16
// format NSQ is 13. One request is taken every cycle while o_s_tready is
// high; the pipeline depth is set by the digit-serial square root.
// Every stage holds its own valid bit and only stops when the stage after it
// is full and stopped, so bubbles close up and o_s_tready stays high while any
// stage is empty, even when a finished result is held at the output.
// When i_m_tready is low the result stays on o_m_tdata/o_m_tuser unchanged.
// Synchronous active-low reset empties all stages; no data is lost or repeated.
module rusanov_momentum_flux_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // slave stream
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // fields: vel_left, vel_right, depth_left, depth_right
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]          i_s_tdata,
    // master stream
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // fields: momentum_flux
    output logic [((DATA_WIDTH+7)/8)*8-1:0]            o_m_tdata,
    // fields: saturated
    output logic                                       o_m_tuser
);
    import rmf_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int OW  = ((W + 7) / 8) * 8;
    localparam int QW  = 2 * W;
    localparam int GW  = F + G_INT_BITS;
    localparam logic [63:0] G_FULL  =
        ((64'(G_NUM) << F) + 64'(G_DEN / 2)) / 64'(G_DEN);
    localparam logic [63:0] G2_FULL =
        ((64'(G2_NUM) << F) + 64'(G2_DEN / 2)) / 64'(G2_DEN);
    localparam logic [GW-1:0] G_Q  = G_FULL[GW-1:0];
    localparam logic [GW-1:0] G2_Q = G2_FULL[GW-1:0];
    // radicand g*h, root digits and stages
    localparam int RW  = W - 1 + GW;
    localparam int NSQ = (RW + 2 * SQ_STEPS - 1) / (2 * SQ_STEPS);
    localparam int SD  = SQ_STEPS * NSQ;
    localparam int XW  = 2 * SD;
    localparam int CW  = ((SD > W) ? SD : W) + 1;
    localparam int PW  = GW + W;
    localparam int MW  = CW + W + 2;
    localparam int NW  = 3 * W + F + 6;
    localparam int NS  = NSQ + 5;
    localparam logic signed [NW-1:0] HALF  = NW'(1) << (2 * F);
    localparam logic signed [NW-1:0] MAX_V = (NW'(1) << (W - 1)) - NW'(1);
    localparam logic signed [NW-1:0] MIN_V = -(NW'(1) << (W - 1));

    // stage enables and valid bits
    logic [NS-1:0] en;
    logic [NS-1:0] r_vld;

    // front stage and square root stages carry these
    logic signed [QW-1:0] r_q     [0:NSQ][2];
    logic        [QW-1:0] r_h2    [0:NSQ][2];
    logic signed [W-1:0]  r_u     [0:NSQ][2];
    logic        [W-1:0]  r_au    [0:NSQ][2];
    logic                 r_dry   [0:NSQ];
    logic        [XW-1:0] r_sx    [0:NSQ][2];
    logic        [SD+1:0] r_srem  [0:NSQ][2];
    logic        [SD-1:0] r_sroot [0:NSQ][2];

    logic        [XW-1:0] n_sx    [1:NSQ][2];
    logic        [SD+1:0] n_srem  [1:NSQ][2];
    logic        [SD-1:0] n_sroot [1:NSQ][2];

    // product stages
    logic        [CW-1:0]  r_c;
    logic signed [QW:0]    r_dq;
    logic signed [2*W:0]   r_uqlo [2];
    logic signed [2*W-1:0] r_uqhi [2];
    logic        [PW-1:0]  r_ghlo [2];
    logic        [PW-1:0]  r_ghhi [2];
    logic                  r_dry_b;
    logic signed [NW-1:0]  r_pa;
    logic signed [NW-1:0]  r_pb;
    logic signed [MW-1:0]  r_cdlo;
    logic signed [MW-1:0]  r_cdhi;
    logic                  r_dry_c;
    logic signed [NW-1:0]  r_p;
    logic signed [NW-1:0]  r_ct;
    logic                  r_dry_d;
    logic        [W-1:0]   r_flux;
    logic                  r_sat;

    // input decode
    logic signed [W-1:0]  in_u  [2];
    logic signed [W-1:0]  in_h  [2];
    logic signed [QW-1:0] n_q   [2];
    logic signed [QW-1:0] n_h2  [2];
    logic        [W-1:0]  n_au  [2];
    logic        [XW-1:0] n_gh  [2];
    logic                 n_dry;

    // stage b/c/d/e combinational values
    logic        [CW-1:0]  cs   [2];
    logic        [CW-1:0]  n_c;
    logic signed [QW:0]    n_dq;
    logic signed [2*W:0]   n_uqlo [2];
    logic signed [2*W-1:0] n_uqhi [2];
    logic        [PW-1:0]  n_ghlo [2];
    logic        [PW-1:0]  n_ghhi [2];
    logic signed [NW-1:0]  tu   [2];
    logic signed [NW-1:0]  tg   [2];
    logic signed [MW-1:0]  n_cdlo;
    logic signed [MW-1:0]  n_cdhi;
    logic signed [NW-1:0]  n_sum;
    logic signed [NW-1:0]  n_sh;
    logic        [W-1:0]   n_flux;
    logic                  n_sat;

    // backpressure: a stage moves when it is empty or the next one moves
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || i_m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // front stage: momenta, squared depths, g*h radicands
    always_comb begin
        in_u[0] = $signed(i_s_tdata[W-1:0]);
        in_u[1] = $signed(i_s_tdata[2*W-1:W]);
        in_h[0] = $signed(i_s_tdata[3*W-1:2*W]);
        in_h[1] = $signed(i_s_tdata[4*W-1:3*W]);
        for (int s = 0; s < 2; s++) begin
            n_q[s]  = in_u[s] * in_h[s];
            n_h2[s] = in_h[s] * in_h[s];
            n_au[s] = in_u[s][W-1] ? W'(-in_u[s]) : W'(in_u[s]);
            n_gh[s] = in_h[s][W-1] ? '0 : XW'(G_Q * in_h[s][W-2:0]);
        end
        n_dry = (in_h[0][W-1] || (in_h[0] == '0)) && (in_h[1][W-1] || (in_h[1] == '0));
    end

    // digit-serial square root, two digits per stage
    always_comb begin
        logic [XW-1:0] x;
        logic [SD+1:0] rem;
        logic [SD+1:0] trial;
        logic [SD-1:0] root;
        for (int k = 1; k <= NSQ; k++) begin
            for (int s = 0; s < 2; s++) begin
                x    = r_sx[k-1][s];
                rem  = r_srem[k-1][s];
                root = r_sroot[k-1][s];
                for (int j = 0; j < SQ_STEPS; j++) begin
                    rem   = {rem[SD-1:0], x[XW-1:XW-2]};
                    trial = {root, 2'b01};
                    if (rem >= trial) begin
                        rem  = rem - trial;
                        root = {root[SD-2:0], 1'b1};
                    end else begin
                        root = {root[SD-2:0], 1'b0};
                    end
                    x = x << 2;
                end
                n_sx[k][s]    = x;
                n_srem[k][s]  = rem;
                n_sroot[k][s] = root;
            end
        end
    end

    // front stage and square root stage registers
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int s = 0; s < 2; s++) begin
                r_q[0][s]     <= n_q[s];
                r_h2[0][s]    <= n_h2[s];
                r_u[0][s]     <= in_u[s];
                r_au[0][s]    <= n_au[s];
                r_sx[0][s]    <= n_gh[s];
                r_srem[0][s]  <= '0;
                r_sroot[0][s] <= '0;
            end
            r_dry[0] <= n_dry;
        end
        for (int k = 1; k <= NSQ; k++) begin
            if (en[k]) begin
                for (int s = 0; s < 2; s++) begin
                    r_sx[k][s]    <= n_sx[k][s];
                    r_srem[k][s]  <= n_srem[k][s];
                    r_sroot[k][s] <= n_sroot[k][s];
                    r_q[k][s]     <= r_q[k-1][s];
                    r_h2[k][s]    <= r_h2[k-1][s];
                    r_u[k][s]     <= r_u[k-1][s];
                    r_au[k][s]    <= r_au[k-1][s];
                end
                r_dry[k] <= r_dry[k-1];
            end
        end
    end

    // stage b: wave speed, momentum difference, first partial products
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            cs[s]     = CW'(r_au[NSQ][s]) + CW'(r_sroot[NSQ][s]);
            n_uqlo[s] = r_u[NSQ][s] * $signed({1'b0, r_q[NSQ][s][W-1:0]});
            n_uqhi[s] = r_u[NSQ][s] * $signed(r_q[NSQ][s][QW-1:W]);
            n_ghlo[s] = G2_Q * r_h2[NSQ][s][W-1:0];
            n_ghhi[s] = G2_Q * r_h2[NSQ][s][QW-1:W];
        end
        n_c  = (cs[1] > cs[0]) ? cs[1] : cs[0];
        n_dq = r_q[NSQ][1] - r_q[NSQ][0];
    end

    always_ff @(posedge i_clk) begin
        if (en[NSQ+1]) begin
            r_c     <= n_c;
            r_dq    <= n_dq;
            r_uqlo  <= n_uqlo;
            r_uqhi  <= n_uqhi;
            r_ghlo  <= n_ghlo;
            r_ghhi  <= n_ghhi;
            r_dry_b <= r_dry[NSQ];
        end
    end

    // stage c: wave speed times momentum difference, join per-side terms
    always_comb begin
        for (int s = 0; s < 2; s++) begin
            tu[s] = (NW'(r_uqhi[s]) <<< W) + NW'(r_uqlo[s]);
            tg[s] = $signed((NW'(r_ghhi[s]) << W) + NW'(r_ghlo[s]));
        end
        n_cdlo = $signed({1'b0, r_c}) * $signed({1'b0, r_dq[W-1:0]});
        n_cdhi = $signed({1'b0, r_c}) * $signed(r_dq[QW:W]);
    end

    always_ff @(posedge i_clk) begin
        if (en[NSQ+2]) begin
            r_pa    <= tu[0] + tg[0];
            r_pb    <= tu[1] + tg[1];
            r_cdlo  <= n_cdlo;
            r_cdhi  <= n_cdhi;
            r_dry_c <= r_dry_b;
        end
    end

    // stage d: flux sum and diffusion term
    always_ff @(posedge i_clk) begin
        if (en[NSQ+3]) begin
            r_p     <= r_pa + r_pb;
            r_ct    <= (NW'(r_cdhi) <<< W) + NW'(r_cdlo);
            r_dry_d <= r_dry_c;
        end
    end

    // stage e: round half up, scale, saturate; zero flux when both sides are dry
    always_comb begin
        n_sum = r_p - r_ct + HALF;
        n_sh  = n_sum >>> (2 * F + 1);
        if (r_dry_d) begin
            n_flux = '0;
            n_sat  = 1'b0;
        end else if (n_sh > MAX_V) begin
            n_flux = MAX_V[W-1:0];
            n_sat  = 1'b1;
        end else if (n_sh < MIN_V) begin
            n_flux = MIN_V[W-1:0];
            n_sat  = 1'b1;
        end else begin
            n_flux = n_sh[W-1:0];
            n_sat  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_flux <= n_flux;
            r_sat  <= n_sat;
        end
    end

    assign o_m_tvalid = r_vld[NS-1];
    assign o_m_tdata  = OW'(r_flux);
    assign o_m_tuser  = r_sat;

endmodule
